/* src/three_band_stereo_meter_defines.svh */
// Assertion macros shared by the checker of the three-band stereo meter.
// Needs nothing else; included by the files that hold assertions.
`ifndef THREE_BAND_STEREO_METER_DEFINES_SVH
`define THREE_BAND_STEREO_METER_DEFINES_SVH

// Antecedent holds at one edge, consequent must hold at the next, outside reset.
`define TBSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbsm check failed");

// Something that must hold in the cycle after reset is applied.
`define TBSM_ASSERT_AFTER_RESET(name, clk, rst, cons) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("tbsm reset check failed");

`endif

/* src/tbsm_pkg.sv */
// Package of the three-band stereo meter: widths, register indexes, sequencer
// states and the divider status type. Depends on nothing.
`default_nettype none

package tbsm_pkg;

  localparam int MAX_BLOCK_FRAMES_DEF = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_SHIFT = 24 - SAMPLE_BITS;

  localparam int OPW = 25;
  localparam int PRODW = 2 * OPW;
  localparam int NUMW = 49;

  localparam logic [3:0] REG_LOW_BAND_COEF = 4'd0;
  localparam logic [3:0] REG_HIGH_SPLIT_COEF = 4'd1;
  localparam logic [3:0] REG_OVERALL_ATTACK = 4'd2;
  localparam logic [3:0] REG_OVERALL_DECAY = 4'd3;
  localparam logic [3:0] REG_BAND_ATTACK = 4'd4;
  localparam logic [3:0] REG_BAND_DECAY = 4'd5;
  localparam logic [3:0] REG_SPATIAL_WEIGHT = 4'd6;
  localparam logic [3:0] REG_SILENCE_THRESHOLD = 4'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_MUL,
    ST_FILT_WB,
    ST_EN_MUL,
    ST_EN_WB,
    ST_PEAK,
    ST_BL_M0,
    ST_BL_M1,
    ST_BL_WB,
    ST_SP_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic signed [15:0] quot;
  } div_status_t;

endpackage

`default_nettype wire

/* src/tbsm_mul.sv */
// Shared signed multiplier of the meter, with a registered product.
// Uses tbsm_pkg for the operand width.
`default_nettype none

module tbsm_mul (
  input  logic                               clk,
  input  logic signed [tbsm_pkg::OPW-1:0]    a,
  input  logic signed [tbsm_pkg::OPW-1:0]    b,
  output logic signed [tbsm_pkg::PRODW-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

/* src/tbsm_div.sv */
// Restoring divider that gives a signed Q1.15 ratio one bit per cycle.
// Uses tbsm_pkg for widths and the status struct.
`default_nettype none

module tbsm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tbsm_pkg::NUMW-1:0]  num,
  input  logic [tbsm_pkg::NUMW-1:0]         den,
  output tbsm_pkg::div_status_t             status
);

  logic                         busy;
  logic                         done;
  logic [3:0]                   cnt;
  logic [tbsm_pkg::NUMW-1:0]    rem;
  logic [tbsm_pkg::NUMW-1:0]    den_r;
  logic [14:0]                  acc;
  logic                         neg;
  logic signed [15:0]           quot;

  logic [tbsm_pkg::NUMW-1:0]    mag;
  logic [tbsm_pkg::NUMW:0]      rem_sh;
  logic                         take;
  logic [14:0]                  acc_next;

  assign mag = num[tbsm_pkg::NUMW-1] ? tbsm_pkg::NUMW'(-num) : tbsm_pkg::NUMW'(num);
  assign rem_sh = {rem, 1'b0};
  assign take = rem_sh >= {1'b0, den_r};
  assign acc_next = {acc[13:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[tbsm_pkg::NUMW-1];
        den_r <= den;
        if (mag >= den) begin
          // Magnitude of one or more saturates at the signed limit.
          quot <= num[tbsm_pkg::NUMW-1] ? -16'sd32768 : 16'sd32767;
          done <= 1'b1;
        end else begin
          rem <= mag;
          acc <= '0;
          cnt <= 4'd15;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? tbsm_pkg::NUMW'(rem_sh - {1'b0, den_r}) : tbsm_pkg::NUMW'(rem_sh);
        acc <= acc_next;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});
        end
      end
    end
  end

  assign status.done = done;
  assign status.quot = quot;

endmodule

`default_nettype wire

/* src/three_band_stereo_meter.sv */
// Three-band stereo meter top level: sequencer, state and configuration.
// Uses tbsm_pkg, tbsm_mul and tbsm_div.
//
// From acceptance until in_ready returns, a frame runs thirteen multiplies
// (four filter steps, nine energy products), each a multiply and a
// write-back state on the one shared multiplier, then a peak state. A frame
// that ends a block then runs the block-end pass on the same multiplier plus
// the one-bit-per-cycle divider: four level updates, one check state per
// band, and for each non-silent band a division and a blend for pan and (mid
// and treble) phase, then an output state. The result sits in an output
// register; the next frame is taken while it waits, and a further block end
// waits for it to be taken.
`default_nettype none

module three_band_stereo_meter #(
  parameter int MAX_BLOCK_FRAMES = tbsm_pkg::MAX_BLOCK_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        overall_level,
  output logic [14:0]        bass_level,
  output logic [14:0]        mid_level,
  output logic [14:0]        treble_level,
  output logic signed [15:0] bass_pan,
  output logic signed [15:0] mid_pan,
  output logic signed [15:0] treble_pan,
  output logic signed [15:0] mid_phase,
  output logic signed [15:0] treble_phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int OPW = tbsm_pkg::OPW;
  localparam int PRODW = tbsm_pkg::PRODW;
  localparam int NUMW = tbsm_pkg::NUMW;

  function automatic logic [14:0] peak_of(input logic signed [OPW-1:0] v);
    logic [OPW:0] m;
    logic [OPW-8:0] s;
    m = v[OPW-1] ? (OPW+1)'(-$signed({v[OPW-1], v})) : (OPW+1)'({1'b0, v});
    s = m[OPW:8];
    peak_of = (s > (OPW-7)'(32767)) ? 15'd32767 : s[14:0];
  endfunction

  tbsm_pkg::state_t state, state_next;

  logic [15:0] c_low, c_split, ov_att, ov_dec, bd_att, bd_dec, sp_w;
  logic [19:0] thr;

  logic signed [23:0] x0, x1;
  logic               be_flag;
  logic signed [23:0] bf [2];
  logic signed [23:0] sf [2];
  logic [47:0]        esum_l [3];
  logic [47:0]        esum_r [3];
  logic signed [47:0] xsum [3];
  logic [14:0]        peak [4];
  logic signed [15:0] rd [9];
  logic [CNT_W-1:0]   cnt;
  logic [1:0]         fi, band, kind;
  logic [3:0]         tgt;
  logic               phase_sel;
  logic signed [PRODW-1:0] acc;
  logic signed [15:0] est;

  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [PRODW-1:0] prod;
  logic                    div_start;
  logic signed [NUMW-1:0]  div_num;
  logic [NUMW-1:0]         tot;
  tbsm_pkg::div_status_t   div_st;

  logic signed [OPW-1:0] band_l [3];
  logic signed [OPW-1:0] band_r [3];
  logic signed [23:0]    x_in0, x_in1;

  // Filter step signals.
  logic signed [23:0] fs_sel, fx_sel;
  logic [15:0]        fcoef;
  logic signed [34:0] f_delta;
  logic signed [35:0] f_sum;
  logic signed [23:0] f_new;

  // Energy step signals.
  logic signed [33:0] e_t;
  logic [48:0]        e_sum;
  logic signed [48:0] x_sum;

  // Blend signals.
  logic signed [15:0] cur;
  logic               is_lvl, up;
  logic [3:0]         tgt_m1;
  logic [14:0]        pk;
  logic [15:0]        att, dec;
  logic [16:0]        k0, b1;
  logic signed [OPW-1:0] a1;
  logic signed [PRODW:0] bl_sum;
  logic signed [34:0]    bl_sh;
  logic signed [15:0]    bl_res;

  logic       end_now, silent, out_load;
  logic [14:0] pb [3];
  logic [14:0] pfull;

  assign x_in0 = 24'(signed'(left_sample[tbsm_pkg::SAMPLE_BITS-1:0])) <<<
                 tbsm_pkg::SAMPLE_SHIFT;
  assign x_in1 = 24'(signed'(right_sample[tbsm_pkg::SAMPLE_BITS-1:0])) <<<
                 tbsm_pkg::SAMPLE_SHIFT;

  always_comb begin
    band_l[0] = OPW'(bf[0]);
    band_r[0] = OPW'(bf[1]);
    band_l[1] = OPW'(sf[0]) - OPW'(bf[0]);
    band_r[1] = OPW'(sf[1]) - OPW'(bf[1]);
    band_l[2] = OPW'(x0) - OPW'(sf[0]);
    band_r[2] = OPW'(x1) - OPW'(sf[1]);
  end

  tbsm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  tbsm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(tot), .status(div_st)
  );

  // Filter operands and write-back value.
  assign fs_sel = fi[1] ? sf[fi[0]] : bf[fi[0]];
  assign fx_sel = fi[0] ? x1 : x0;
  assign fcoef = fi[1] ? c_split : c_low;
  assign f_delta = 35'((prod + PRODW'(32768)) >>> 16);
  assign f_sum = 36'(fs_sel) + 36'(f_delta);
  always_comb begin
    if (f_sum > 36'sd8388607) begin
      f_new = 24'sh7FFFFF;
    end else if (f_sum < -36'sd8388608) begin
      f_new = -24'sd8388608;
    end else begin
      f_new = f_sum[23:0];
    end
  end

  // Energy write-back: squares add without sign, the cross term saturates both ways.
  assign e_t = prod[PRODW-1:16];
  assign e_sum = {1'b0, (kind == 2'd0) ? esum_l[band] : esum_r[band]} + 49'(e_t[32:0]);
  assign x_sum = 49'(xsum[band]) + 49'(e_t);

  // Blend of a smoothed reading: cur*k0 + a1*b1 (+ rounding for pan and phase), then >> 16.
  assign cur = rd[tgt];
  assign is_lvl = tgt < 4'd4;
  assign tgt_m1 = tgt - 4'd1;
  assign pk = (tgt == 4'd0) ? peak[3] : peak[tgt_m1[1:0]];
  assign att = (tgt == 4'd0) ? ov_att : bd_att;
  assign dec = (tgt == 4'd0) ? ov_dec : bd_dec;
  assign up = $signed({1'b0, pk}) > cur;
  assign k0 = is_lvl ? (up ? 17'd65536 - 17'(att) : 17'(dec)) : 17'd65536 - 17'(sp_w);
  assign a1 = is_lvl ? (up ? OPW'($signed({1'b0, pk})) : '0) : OPW'(est);
  assign b1 = is_lvl ? 17'(att) : 17'(sp_w);
  assign bl_sum = (PRODW+1)'(acc) + (PRODW+1)'(prod) +
                  (is_lvl ? '0 : (PRODW+1)'(32768));
  assign bl_sh = bl_sum[PRODW:16];
  always_comb begin
    if (bl_sh > 35'sd32767) begin
      bl_res = 16'sd32767;
    end else if (bl_sh < -35'sd32768) begin
      bl_res = -16'sd32768;
    end else begin
      bl_res = bl_sh[15:0];
    end
  end

  assign tot = {1'b0, esum_l[band]} + {1'b0, esum_r[band]};
  assign silent = (tot == '0) || (tot < NUMW'(thr));
  assign div_num = phase_sel ? {xsum[band], 1'b0}
                             : $signed({1'b0, esum_r[band]} - {1'b0, esum_l[band]});

  assign end_now = be_flag || (cnt + CNT_W'(1) == CNT_W'(MAX_BLOCK_FRAMES));
  assign out_load = (state == tbsm_pkg::ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      pb[b] = (peak_of(band_r[b]) > peak_of(band_l[b])) ? peak_of(band_r[b])
                                                         : peak_of(band_l[b]);
    end
    pfull = (peak_of(OPW'(x1)) > peak_of(OPW'(x0))) ? peak_of(OPW'(x1))
                                                    : peak_of(OPW'(x0));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tbsm_pkg::ST_IDLE: begin
        if (in_valid) state_next = tbsm_pkg::ST_FILT_MUL;
      end
      tbsm_pkg::ST_FILT_MUL: state_next = tbsm_pkg::ST_FILT_WB;
      tbsm_pkg::ST_FILT_WB: begin
        state_next = (fi == 2'd3) ? tbsm_pkg::ST_EN_MUL : tbsm_pkg::ST_FILT_MUL;
      end
      tbsm_pkg::ST_EN_MUL: state_next = tbsm_pkg::ST_EN_WB;
      tbsm_pkg::ST_EN_WB: begin
        state_next = (band == 2'd2 && kind == 2'd2) ? tbsm_pkg::ST_PEAK
                                                    : tbsm_pkg::ST_EN_MUL;
      end
      tbsm_pkg::ST_PEAK: begin
        state_next = end_now ? tbsm_pkg::ST_BL_M0 : tbsm_pkg::ST_IDLE;
      end
      tbsm_pkg::ST_BL_M0: state_next = tbsm_pkg::ST_BL_M1;
      tbsm_pkg::ST_BL_M1: state_next = tbsm_pkg::ST_BL_WB;
      tbsm_pkg::ST_BL_WB: begin
        if (tgt < 4'd3) begin
          state_next = tbsm_pkg::ST_BL_M0;
        end else if (tgt == 4'd3) begin
          state_next = tbsm_pkg::ST_SP_CHK;
        end else if (tgt < 4'd7 && band != 2'd0) begin
          state_next = tbsm_pkg::ST_DIV_GO;
        end else begin
          state_next = (band == 2'd2) ? tbsm_pkg::ST_OUT : tbsm_pkg::ST_SP_CHK;
        end
      end
      tbsm_pkg::ST_SP_CHK: begin
        if (!silent) begin
          state_next = tbsm_pkg::ST_DIV_GO;
        end else begin
          state_next = (band == 2'd2) ? tbsm_pkg::ST_OUT : tbsm_pkg::ST_SP_CHK;
        end
      end
      tbsm_pkg::ST_DIV_GO: state_next = tbsm_pkg::ST_DIV_WAIT;
      tbsm_pkg::ST_DIV_WAIT: begin
        if (div_st.done) state_next = tbsm_pkg::ST_BL_M0;
      end
      tbsm_pkg::ST_OUT: begin
        if (!out_valid || out_ready) state_next = tbsm_pkg::ST_IDLE;
      end
      default: state_next = tbsm_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    in_ready = 1'b0;
    case (state)
      tbsm_pkg::ST_IDLE: in_ready = 1'b1;
      tbsm_pkg::ST_FILT_MUL: begin
        mul_a = OPW'(fx_sel) - OPW'(fs_sel);
        mul_b = $signed({9'b0, fcoef});
      end
      tbsm_pkg::ST_EN_MUL: begin
        mul_a = (kind == 2'd1) ? band_r[band] : band_l[band];
        mul_b = (kind == 2'd0) ? band_l[band] : band_r[band];
      end
      tbsm_pkg::ST_BL_M0: begin
        mul_a = OPW'(cur);
        mul_b = $signed({8'b0, k0});
      end
      tbsm_pkg::ST_BL_M1: begin
        mul_a = a1;
        mul_b = $signed({8'b0, b1});
      end
      tbsm_pkg::ST_DIV_GO: div_start = 1'b1;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_low <= 16'd1311;
      c_split <= 16'd26214;
      ov_att <= 16'd19661;
      ov_dec <= 16'd64553;
      bd_att <= 16'd32768;
      bd_dec <= 16'd62259;
      sp_w <= 16'd9830;
      thr <= 20'd107;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbsm_pkg::REG_LOW_BAND_COEF: c_low <= cfg_data[15:0];
        tbsm_pkg::REG_HIGH_SPLIT_COEF: c_split <= cfg_data[15:0];
        tbsm_pkg::REG_OVERALL_ATTACK: ov_att <= cfg_data[15:0];
        tbsm_pkg::REG_OVERALL_DECAY: ov_dec <= cfg_data[15:0];
        tbsm_pkg::REG_BAND_ATTACK: bd_att <= cfg_data[15:0];
        tbsm_pkg::REG_BAND_DECAY: bd_dec <= cfg_data[15:0];
        tbsm_pkg::REG_SPATIAL_WEIGHT: sp_w <= cfg_data[15:0];
        tbsm_pkg::REG_SILENCE_THRESHOLD: thr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbsm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      fi <= '0;
      band <= '0;
      kind <= '0;
      tgt <= '0;
      phase_sel <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        bf[i] <= '0;
        sf[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        esum_l[i] <= '0;
        esum_r[i] <= '0;
        xsum[i] <= '0;
      end
      for (int i = 0; i < 4; i++) peak[i] <= '0;
      for (int i = 0; i < 9; i++) rd[i] <= (i >= 7) ? 16'sd32767 : 16'sd0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        tbsm_pkg::ST_IDLE: begin
          if (in_valid) begin
            x0 <= x_in0;
            x1 <= x_in1;
            be_flag <= block_end;
            fi <= '0;
          end
        end
        tbsm_pkg::ST_FILT_WB: begin
          if (fi[1]) begin
            sf[fi[0]] <= f_new;
          end else begin
            bf[fi[0]] <= f_new;
          end
          fi <= fi + 2'd1;
          band <= '0;
          kind <= '0;
        end
        tbsm_pkg::ST_EN_WB: begin
          if (kind == 2'd2) begin
            if (x_sum > 49'sh7FFFFFFFFFFF) begin
              xsum[band] <= 48'sh7FFFFFFFFFFF;
            end else if (x_sum < -49'sh800000000000) begin
              xsum[band] <= 48'sh800000000000;
            end else begin
              xsum[band] <= x_sum[47:0];
            end
            kind <= '0;
            band <= band + 2'd1;
          end else begin
            if (kind == 2'd0) begin
              esum_l[band] <= e_sum[48] ? 48'hFFFFFFFFFFFF : e_sum[47:0];
            end else begin
              esum_r[band] <= e_sum[48] ? 48'hFFFFFFFFFFFF : e_sum[47:0];
            end
            kind <= kind + 2'd1;
          end
        end
        tbsm_pkg::ST_PEAK: begin
          for (int b = 0; b < 3; b++) begin
            if (pb[b] > peak[b]) peak[b] <= pb[b];
          end
          if (pfull > peak[3]) peak[3] <= pfull;
          cnt <= end_now ? '0 : cnt + CNT_W'(1);
          tgt <= '0;
        end
        tbsm_pkg::ST_BL_M1: acc <= prod;
        tbsm_pkg::ST_BL_WB: begin
          rd[tgt] <= bl_res;
          if (tgt < 4'd3) begin
            tgt <= tgt + 4'd1;
          end else if (tgt == 4'd3) begin
            band <= '0;
          end else if (tgt < 4'd7 && band != 2'd0) begin
            phase_sel <= 1'b1;
            tgt <= 4'd6 + 4'(band);
          end else if (band != 2'd2) begin
            band <= band + 2'd1;
          end
        end
        tbsm_pkg::ST_SP_CHK: begin
          if (!silent) begin
            phase_sel <= 1'b0;
            tgt <= 4'd4 + 4'(band);
          end else if (band != 2'd2) begin
            band <= band + 2'd1;
          end
        end
        tbsm_pkg::ST_DIV_WAIT: begin
          if (div_st.done) est <= div_st.quot;
        end
        tbsm_pkg::ST_OUT: begin
          if (out_load) begin
            for (int i = 0; i < 3; i++) begin
              esum_l[i] <= '0;
              esum_r[i] <= '0;
              xsum[i] <= '0;
            end
            for (int i = 0; i < 4; i++) peak[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      overall_level <= rd[0][14:0];
      bass_level <= rd[1][14:0];
      mid_level <= rd[2][14:0];
      treble_level <= rd[3][14:0];
      bass_pan <= rd[4];
      mid_pan <= rd[5];
      treble_pan <= rd[6];
      mid_phase <= rd[7];
      treble_phase <= rd[8];
    end
  end

endmodule

`default_nettype wire

/* src/tbsm_checker.sv */
// Port-level checks of the three-band stereo meter and their bind.
// Uses the assertion macros of three_band_stereo_meter_defines.svh.
`default_nettype none
`include "three_band_stereo_meter_defines.svh"

module tbsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] overall_level
);

  // A stalled result stays and holds its value.
  `TBSM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TBSM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(overall_level))
  // The block works on one frame at a time.
  `TBSM_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)
  `TBSM_ASSERT_AFTER_RESET(a_no_out_after_reset, clk, rst, !out_valid)

endmodule

bind three_band_stereo_meter tbsm_checker u_tbsm_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .overall_level(overall_level)
);

`default_nettype wire
